### rtl/tcc_pkg.sv
package tcc_pkg;

    // Field widths of the command and result channels
    localparam int ROW_W    = 5;
    localparam int COL_W    = 7;
    localparam int CHAR_W   = 8;
    localparam int ADDR_W   = 11;
    localparam int WORD_W   = 16;
    localparam int COLOR_W  = 4;

    // Configuration port
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    // Command codes
    localparam logic CMD_PUT = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_BACKGROUND = 2'd0;
    localparam logic [1:0] REG_FOREGROUND = 2'd1;
    localparam logic [1:0] REG_CURSOR     = 2'd2;

    // Register reset values
    localparam logic [COLOR_W-1:0] BACKGROUND_RESET = 4'h0;
    localparam logic [COLOR_W-1:0] FOREGROUND_RESET = 4'hF;
    localparam logic               CURSOR_RESET     = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] background_color;
        logic [COLOR_W-1:0] foreground_color;
        logic               cursor_shown;
    } cfg_t;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [WORD_W-1:0] write_word;
        logic              cursor_valid;
        logic [ADDR_W-1:0] cursor_position;
    } result_t;

endpackage

### rtl/tcc_if.sv
// Command channel
interface tcc_cmd_if import tcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              command;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  target_row;
    logic [COL_W-1:0]  target_col;

    modport source (output valid, output command, output char_code,
                    output target_row, output target_col, input ready);
    modport sink   (input valid, input command, input char_code,
                    input target_row, input target_col, output ready);
endinterface

// Result channel
interface tcc_res_if import tcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [WORD_W-1:0] write_word;
    logic              cursor_valid;
    logic [ADDR_W-1:0] cursor_position;

    modport source (output valid, output write_valid, output write_address,
                    output write_word, output cursor_valid, output cursor_position,
                    input ready);
    modport sink   (input valid, input write_valid, input write_address,
                    input write_word, input cursor_valid, input cursor_position,
                    output ready);
endinterface

### rtl/text_console_cursor_writer_unit.sv
// Channel   Dir  Handshake       Payload
// cmd       in   valid / ready   command, char_code, target_row, target_col
// res       out  valid / ready   write_valid, write_address, write_word,
//                                cursor_valid, cursor_position
// apb       in   psel / penable  paddr, pwdata, prdata (pready tied high)
//
// One command per cycle is taken while the result is not stalled; its result
// passes through the command register, then the result register, and is on
// the result port from the result register.
// The cursor update from the command register to the result register sets it.
// Reset clears the cursor to row 0, column 0 and loads the colour defaults.
// A stalled result holds; the command register still takes a transfer in
// the cycle that the result is taken.
module text_console_cursor_writer_unit import tcc_pkg::*;
#(
    parameter int unsigned ROWS      = 25,
    parameter int unsigned COLS      = 80,
    parameter int unsigned TAB_WIDTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    tcc_cmd_if.sink            cmd,
    tcc_res_if.source          res
);

    cfg_t              cfg;
    logic              cmd_valid_reg;
    logic              cmd_valid_next;
    logic              command_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [ROW_W-1:0]  trow_reg;
    logic [COL_W-1:0]  tcol_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    result_t           res_reg;
    result_t           res_next;
    logic [ROW_W-1:0]  cursor_row_reg;
    logic [ROW_W-1:0]  cursor_row_next;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [COL_W-1:0]  cursor_col_next;
    logic              res_free;
    logic              advance;
    logic              cmd_take;

    assign pready = 1'b1;

    tcc_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tcc_cursor_step #(
        .ROWS      (ROWS),
        .COLS      (COLS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_step
    (
        .cfg        (cfg),
        .command    (command_reg),
        .char_code  (char_reg),
        .target_row (trow_reg),
        .target_col (tcol_reg),
        .row        (cursor_row_reg),
        .col        (cursor_col_reg),
        .row_next   (cursor_row_next),
        .col_next   (cursor_col_next),
        .result     (res_next)
    );

    // Pipeline control
    assign res_free       = !res_valid_reg || res.ready;
    assign advance        = cmd_valid_reg && res_free;
    assign cmd.ready      = !cmd_valid_reg || advance;
    assign cmd_take       = cmd.valid && cmd.ready;
    assign cmd_valid_next = cmd_take || (cmd_valid_reg && !advance);
    assign res_valid_next = advance || (res_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg  <= 1'b0;
            res_valid_reg  <= 1'b0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                cursor_row_reg <= cursor_row_next;
                cursor_col_reg <= cursor_col_next;
            end
        end
    end

    // Hold the command payload
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            command_reg <= cmd.command;
            char_reg    <= cmd.char_code;
            trow_reg    <= cmd.target_row;
            tcol_reg    <= cmd.target_col;
        end
    end

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.write_valid     = res_reg.write_valid;
    assign res.write_address   = res_reg.write_address;
    assign res.write_word      = res_reg.write_word;
    assign res.cursor_valid    = res_reg.cursor_valid;
    assign res.cursor_position = res_reg.cursor_position;

    // The cursor stays on the screen
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_row_reg < ROW_W'(ROWS))
        else $error("cursor row beyond screen");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_col_reg < COL_W'(COLS))
        else $error("cursor column beyond screen");

    // Without a write the write fields are zero
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_reg.write_valid |->
            res_reg.write_address == '0 && res_reg.write_word == '0)
        else $error("write fields set without a write");

    // A result only moves when a command advances into it
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(cmd_valid_reg))
        else $error("result without a command");

endmodule

### rtl/tcc_cfg_regs.sv
module tcc_cfg_regs import tcc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    logic [COLOR_W-1:0] background_reg;
    logic [COLOR_W-1:0] foreground_reg;
    logic               cursor_shown_reg;
    logic               wr_en;
    logic [1:0]         reg_index;

    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    // Take a write in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            background_reg   <= BACKGROUND_RESET;
            foreground_reg   <= FOREGROUND_RESET;
            cursor_shown_reg <= CURSOR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_BACKGROUND: background_reg   <= pwdata[COLOR_W-1:0];
                REG_FOREGROUND: foreground_reg   <= pwdata[COLOR_W-1:0];
                REG_CURSOR:     cursor_shown_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        case (reg_index)
            REG_BACKGROUND: prdata = PDATA_W'(background_reg);
            REG_FOREGROUND: prdata = PDATA_W'(foreground_reg);
            REG_CURSOR:     prdata = PDATA_W'(cursor_shown_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.background_color = background_reg;
    assign cfg.foreground_color = foreground_reg;
    assign cfg.cursor_shown     = cursor_shown_reg;

endmodule

### rtl/tcc_cursor_step.sv
module tcc_cursor_step import tcc_pkg::*;
#(
    parameter int unsigned ROWS      = 25,
    parameter int unsigned COLS      = 80,
    parameter int unsigned TAB_WIDTH = 4
)
(
    input  cfg_t              cfg,
    input  logic              command,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ROW_W-1:0]  target_row,
    input  logic [COL_W-1:0]  target_col,
    input  logic [ROW_W-1:0]  row,
    input  logic [COL_W-1:0]  col,
    output logic [ROW_W-1:0]  row_next,
    output logic [COL_W-1:0]  col_next,
    output result_t           result
);

    localparam int NUM_COLS = 1 << COL_W;

    // Next tab stop for every column, eight bits per entry
    function automatic logic [NUM_COLS*8-1:0] tab_stops();
        logic [NUM_COLS*8-1:0] t;
        t = '0;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            t[c*8 +: 8] = 8'((c / TAB_WIDTH + 1) * TAB_WIDTH);
        end
        return t;
    endfunction

    localparam logic [NUM_COLS*8-1:0] TAB_STOPS = tab_stops();

    logic [ROW_W:0]      row_w;
    logic [COL_W:0]      col_w;
    logic                wvalid;
    logic [ADDR_W:0]     waddr_full;
    logic [ADDR_W:0]     cpos_full;

    // Move the cursor
    always_comb
    begin
        row_w  = {1'b0, row};
        col_w  = {1'b0, col};
        wvalid = 1'b0;
        if (command == CMD_SET)
        begin
            row_w = ({1'b0, target_row} >= (ROW_W+1)'(ROWS)) ?
                    (ROW_W+1)'(ROWS - 1) : {1'b0, target_row};
            col_w = ({1'b0, target_col} >= (COL_W+1)'(COLS)) ?
                    (COL_W+1)'(COLS - 1) : {1'b0, target_col};
        end
        else
        begin
            case (char_code)
                CH_NEWLINE:
                begin
                    row_w = row_w + 1'b1;
                    col_w = '0;
                end
                CH_RETURN:
                begin
                    col_w = '0;
                end
                CH_BACKSPACE:
                begin
                    if (col_w != '0)
                    begin
                        col_w = col_w - 1'b1;
                    end
                end
                CH_TAB:
                begin
                    col_w = TAB_STOPS[{col, 3'b000} +: 8];
                end
                default:
                begin
                    wvalid = 1'b1;
                    col_w  = col_w + 1'b1;
                end
            endcase
            // Wrap the column, then the row
            if (col_w >= (COL_W+1)'(COLS))
            begin
                col_w = '0;
                row_w = row_w + 1'b1;
            end
            if (row_w >= (ROW_W+1)'(ROWS))
            begin
                row_w = '0;
            end
        end
    end

    assign row_next = row_w[ROW_W-1:0];
    assign col_next = col_w[COL_W-1:0];

    // Cell offsets before and after the move
    assign waddr_full = (ADDR_W+1)'(row) * (ADDR_W+1)'(COLS) + (ADDR_W+1)'(col);
    assign cpos_full  = (ADDR_W+1)'(row_next) * (ADDR_W+1)'(COLS)
                      + (ADDR_W+1)'(col_next);

    assign result.write_valid     = wvalid;
    assign result.write_address   = wvalid ? waddr_full[ADDR_W-1:0] : '0;
    assign result.write_word      = wvalid ?
                                    {cfg.background_color, cfg.foreground_color, char_code} :
                                    '0;
    assign result.cursor_valid    = cfg.cursor_shown;
    assign result.cursor_position = cfg.cursor_shown ? cpos_full[ADDR_W-1:0] : '0;

endmodule
